FILE: rtl/jmsp_pkg.sv
package jmsp_pkg;

   localparam int PHASE_W = 5;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_PREFIX     = 5'd0;
   localparam logic [PHASE_W-1:0] PH_MARKER     = 5'd1;
   localparam logic [PHASE_W-1:0] PH_LEN_HI     = 5'd2;
   localparam logic [PHASE_W-1:0] PH_LEN_LO     = 5'd3;
   localparam logic [PHASE_W-1:0] PH_SKIP       = 5'd4;
   localparam logic [PHASE_W-1:0] PH_DQT_HEAD   = 5'd5;
   localparam logic [PHASE_W-1:0] PH_DQT_E8     = 5'd6;
   localparam logic [PHASE_W-1:0] PH_DQT_HI     = 5'd7;
   localparam logic [PHASE_W-1:0] PH_DQT_LO     = 5'd8;
   localparam logic [PHASE_W-1:0] PH_DHT_HEAD   = 5'd9;
   localparam logic [PHASE_W-1:0] PH_DHT_CNT    = 5'd10;
   localparam logic [PHASE_W-1:0] PH_DHT_SYM    = 5'd11;
   localparam logic [PHASE_W-1:0] PH_SOF_P      = 5'd12;
   localparam logic [PHASE_W-1:0] PH_SOF_YH     = 5'd13;
   localparam logic [PHASE_W-1:0] PH_SOF_YL     = 5'd14;
   localparam logic [PHASE_W-1:0] PH_SOF_XH     = 5'd15;
   localparam logic [PHASE_W-1:0] PH_SOF_XL     = 5'd16;
   localparam logic [PHASE_W-1:0] PH_SOF_NF     = 5'd17;
   localparam logic [PHASE_W-1:0] PH_SOF_CID    = 5'd18;
   localparam logic [PHASE_W-1:0] PH_SOF_HV     = 5'd19;
   localparam logic [PHASE_W-1:0] PH_SOF_TQ     = 5'd20;
   localparam logic [PHASE_W-1:0] PH_SOS_NS     = 5'd21;
   localparam logic [PHASE_W-1:0] PH_SOS_CID    = 5'd22;
   localparam logic [PHASE_W-1:0] PH_SOS_TT     = 5'd23;
   localparam logic [PHASE_W-1:0] PH_SOS_SKIP   = 5'd24;
   localparam logic [PHASE_W-1:0] PH_DATA_FIRST = 5'd25;
   localparam logic [PHASE_W-1:0] PH_DATA_HELD  = 5'd26;
   localparam logic [PHASE_W-1:0] PH_STOP       = 5'd27;

   // segment types held while the length is read
   localparam logic [4:0] SEG_SKIP = 5'd0;
   localparam logic [4:0] SEG_DQT  = 5'd1;
   localparam logic [4:0] SEG_DHT  = 5'd2;
   localparam logic [4:0] SEG_SOF  = 5'd3;
   localparam logic [4:0] SEG_SOS  = 5'd4;

   // marker bytes
   localparam logic [7:0] BYTE_PREFIX = 8'hFF;
   localparam logic [7:0] MK_DQT      = 8'hDB;
   localparam logic [7:0] MK_DHT      = 8'hC4;
   localparam logic [7:0] MK_SOF0     = 8'hC0;
   localparam logic [7:0] MK_SOS      = 8'hDA;
   localparam logic [7:0] MK_EOI      = 8'hD9;
   localparam logic [7:0] MK_TEM      = 8'h01;
   localparam logic [7:0] MK_RST_LO   = 8'hD0;
   localparam logic [7:0] MK_SOI      = 8'hD8;

   localparam logic [7:0] QUANT_ENTRIES = 8'd64;
   localparam logic [7:0] HUFF_LENGTHS  = 8'd16;

   // result kinds
   localparam logic [3:0] KIND_QUANT  = 4'd0;
   localparam logic [3:0] KIND_HCOUNT = 4'd1;
   localparam logic [3:0] KIND_HSYM   = 4'd2;
   localparam logic [3:0] KIND_DIM    = 4'd3;
   localparam logic [3:0] KIND_FCOMP  = 4'd4;
   localparam logic [3:0] KIND_SCOMP  = 4'd5;
   localparam logic [3:0] KIND_DATA   = 4'd6;
   localparam logic [3:0] KIND_END    = 4'd7;
   localparam logic [3:0] KIND_ERROR  = 4'd8;

   localparam logic [7:0] DIM_HEIGHT    = 8'd0;
   localparam logic [7:0] DIM_WIDTH     = 8'd1;
   localparam logic [7:0] DIM_PRECISION = 8'd2;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [15:0]        seg_remaining;
      logic [7:0]         field_counter;
      logic [11:0]        symbol_total;
      logic [4:0]         table_info;
      logic [7:0]         high_byte_hold;
      logic [7:0]         components_left;
      logic [7:0]         held_data_byte;
   } state_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic        table_class;
      logic [3:0]  table_id;
      logic        precision;
      logic [7:0]  entry_index;
      logic [15:0] value;
      logic [7:0]  component_id;
      logic [3:0]  h_factor;
      logic [3:0]  v_factor;
      logic [3:0]  table_select;
      logic [3:0]  ac_select;
   } rsp_type;

endpackage

FILE: rtl/jmsp_if.sv
interface jmsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface jmsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic        table_class;
   logic [3:0]  table_id;
   logic        precision;
   logic [7:0]  entry_index;
   logic [15:0] value;
   logic [7:0]  component_id;
   logic [3:0]  h_factor;
   logic [3:0]  v_factor;
   logic [3:0]  table_select;
   logic [3:0]  ac_select;

   modport source (
      output valid, input ready,
      output kind, output table_class, output table_id, output precision,
      output entry_index, output value, output component_id,
      output h_factor, output v_factor, output table_select, output ac_select
   );
   modport sink (
      input valid, output ready,
      input kind, input table_class, input table_id, input precision,
      input entry_index, input value, input component_id,
      input h_factor, input v_factor, input table_select, input ac_select
   );
endinterface

FILE: rtl/jmsp_step.sv
module jmsp_step
   import jmsp_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] byte_in,
   output state_type  next_state,
   output logic       res_valid,
   output rsp_type    res
);

   logic [15:0] seg_len;
   logic [15:0] body_len;
   logic [15:0] rem_dec;
   logic [7:0]  fc_inc;
   logic [11:0] sym_add;
   logic [11:0] sym_dec;
   logic [7:0]  comps_dec;
   logic        in_body;

   assign seg_len   = {cur_state.high_byte_hold, byte_in};
   assign body_len  = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
   assign rem_dec   = cur_state.seg_remaining - 16'd1;
   assign fc_inc    = cur_state.field_counter + 8'd1;
   assign sym_add   = cur_state.symbol_total + {4'd0, byte_in};
   assign sym_dec   = cur_state.symbol_total - 12'd1;
   assign comps_dec = cur_state.components_left - 8'd1;

   always_comb begin
      next_state = cur_state;
      res_valid  = 1'b0;
      res        = '0;
      in_body    = 1'b0;

      case (cur_state.phase)
         PH_PREFIX: begin
            if (byte_in == BYTE_PREFIX) begin
               next_state.phase = PH_MARKER;
            end else begin
               res_valid        = 1'b1;
               res.kind         = KIND_ERROR;
               next_state.phase = PH_STOP;
            end
         end
         PH_MARKER: begin
            if (byte_in == BYTE_PREFIX) begin
               next_state.phase = PH_MARKER;
            end else if (byte_in == MK_EOI) begin
               res_valid        = 1'b1;
               res.kind         = KIND_END;
               next_state.phase = PH_STOP;
            end else if (byte_in == MK_TEM
                         || (byte_in >= MK_RST_LO && byte_in <= MK_SOI)) begin
               next_state.phase = PH_PREFIX;
            end else begin
               case (byte_in)
                  MK_DQT:  next_state.table_info = SEG_DQT;
                  MK_DHT:  next_state.table_info = SEG_DHT;
                  MK_SOF0: next_state.table_info = SEG_SOF;
                  MK_SOS:  next_state.table_info = SEG_SOS;
                  default: next_state.table_info = SEG_SKIP;
               endcase
               next_state.phase = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            next_state.high_byte_hold = byte_in;
            next_state.phase          = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            next_state.seg_remaining = body_len;
            if (body_len == 16'd0) begin
               next_state.phase = (cur_state.table_info == SEG_SOS) ? PH_DATA_FIRST
                                                                    : PH_PREFIX;
            end else begin
               case (cur_state.table_info)
                  SEG_DQT: next_state.phase = PH_DQT_HEAD;
                  SEG_DHT: next_state.phase = PH_DHT_HEAD;
                  SEG_SOF: next_state.phase = PH_SOF_P;
                  SEG_SOS: next_state.phase = PH_SOS_NS;
                  default: next_state.phase = PH_SKIP;
               endcase
            end
         end
         PH_DATA_FIRST: begin
            next_state.held_data_byte = byte_in;
            next_state.phase          = PH_DATA_HELD;
         end
         PH_DATA_HELD: begin
            res_valid = 1'b1;
            if (cur_state.held_data_byte == BYTE_PREFIX && byte_in == MK_EOI) begin
               res.kind         = KIND_END;
               next_state.phase = PH_STOP;
            end else begin
               res.kind                  = KIND_DATA;
               res.value                 = {8'd0, cur_state.held_data_byte};
               next_state.held_data_byte = byte_in;
            end
         end
         PH_SKIP, PH_SOS_SKIP: begin
            in_body = 1'b1;
         end
         PH_DQT_HEAD: begin
            in_body                  = 1'b1;
            next_state.table_info    = {|byte_in[7:4], byte_in[3:0]};
            next_state.field_counter = 8'd0;
            next_state.phase         = (|byte_in[7:4]) ? PH_DQT_HI : PH_DQT_E8;
         end
         PH_DQT_E8, PH_DQT_LO: begin
            in_body         = 1'b1;
            res_valid       = 1'b1;
            res.kind        = KIND_QUANT;
            res.table_id    = cur_state.table_info[3:0];
            res.precision   = cur_state.table_info[4];
            res.entry_index = cur_state.field_counter;
            res.value       = (cur_state.phase == PH_DQT_LO) ? seg_len : {8'd0, byte_in};
            next_state.field_counter = fc_inc;
            if (fc_inc >= QUANT_ENTRIES) begin
               next_state.phase = PH_DQT_HEAD;
            end else begin
               next_state.phase = (cur_state.phase == PH_DQT_LO) ? PH_DQT_HI : PH_DQT_E8;
            end
         end
         PH_DQT_HI: begin
            in_body                   = 1'b1;
            next_state.high_byte_hold = byte_in;
            next_state.phase          = PH_DQT_LO;
         end
         PH_DHT_HEAD: begin
            in_body                  = 1'b1;
            next_state.table_info    = {byte_in[4], byte_in[3:0]};
            next_state.field_counter = 8'd0;
            next_state.symbol_total  = 12'd0;
            next_state.phase         = PH_DHT_CNT;
         end
         PH_DHT_CNT: begin
            in_body         = 1'b1;
            res_valid       = 1'b1;
            res.kind        = KIND_HCOUNT;
            res.table_class = cur_state.table_info[4];
            res.table_id    = cur_state.table_info[3:0];
            res.entry_index = cur_state.field_counter;
            res.value       = {8'd0, byte_in};
            next_state.field_counter = fc_inc;
            next_state.symbol_total  = sym_add;
            if (fc_inc >= HUFF_LENGTHS) begin
               next_state.field_counter = 8'd0;
               // a table with no symbols goes straight to the next table
               next_state.phase = (sym_add != 12'd0) ? PH_DHT_SYM : PH_DHT_HEAD;
            end
         end
         PH_DHT_SYM: begin
            in_body         = 1'b1;
            res_valid       = 1'b1;
            res.kind        = KIND_HSYM;
            res.table_class = cur_state.table_info[4];
            res.table_id    = cur_state.table_info[3:0];
            res.entry_index = cur_state.field_counter;
            res.value       = {8'd0, byte_in};
            next_state.field_counter = fc_inc;
            next_state.symbol_total  = sym_dec;
            next_state.phase = (sym_dec != 12'd0) ? PH_DHT_SYM : PH_DHT_HEAD;
         end
         PH_SOF_P: begin
            in_body          = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KIND_DIM;
            res.entry_index  = DIM_PRECISION;
            res.value        = {8'd0, byte_in};
            next_state.phase = PH_SOF_YH;
         end
         PH_SOF_YH, PH_SOF_XH: begin
            in_body                   = 1'b1;
            next_state.high_byte_hold = byte_in;
            next_state.phase          = cur_state.phase + 5'd1;
         end
         PH_SOF_YL, PH_SOF_XL: begin
            in_body          = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KIND_DIM;
            res.entry_index  = (cur_state.phase == PH_SOF_YL) ? DIM_HEIGHT : DIM_WIDTH;
            res.value        = seg_len;
            next_state.phase = cur_state.phase + 5'd1;
         end
         PH_SOF_NF: begin
            in_body                    = 1'b1;
            next_state.components_left = byte_in;
            next_state.phase           = (byte_in != 8'd0) ? PH_SOF_CID : PH_SKIP;
         end
         PH_SOF_CID: begin
            in_body                   = 1'b1;
            next_state.high_byte_hold = byte_in;
            next_state.phase          = PH_SOF_HV;
         end
         PH_SOF_HV: begin
            in_body                  = 1'b1;
            next_state.field_counter = byte_in;
            next_state.phase         = PH_SOF_TQ;
         end
         PH_SOF_TQ: begin
            in_body          = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KIND_FCOMP;
            res.component_id = cur_state.high_byte_hold;
            res.h_factor     = cur_state.field_counter[7:4];
            res.v_factor     = cur_state.field_counter[3:0];
            res.table_select = byte_in[3:0];
            next_state.components_left = comps_dec;
            next_state.phase = (comps_dec != 8'd0) ? PH_SOF_CID : PH_SKIP;
         end
         PH_SOS_NS: begin
            in_body                    = 1'b1;
            next_state.components_left = byte_in;
            next_state.phase           = (byte_in != 8'd0) ? PH_SOS_CID : PH_SOS_SKIP;
         end
         PH_SOS_CID: begin
            in_body                   = 1'b1;
            next_state.high_byte_hold = byte_in;
            next_state.phase          = PH_SOS_TT;
         end
         PH_SOS_TT: begin
            in_body          = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KIND_SCOMP;
            res.component_id = cur_state.high_byte_hold;
            res.table_select = byte_in[7:4];
            res.ac_select    = byte_in[3:0];
            next_state.components_left = comps_dec;
            next_state.phase = (comps_dec != 8'd0) ? PH_SOS_CID : PH_SOS_SKIP;
         end
         default: begin
            next_state.phase = PH_STOP;
         end
      endcase

      // the segment length overrides the structure when it runs out
      if (in_body) begin
         next_state.seg_remaining = rem_dec;
         if (rem_dec == 16'd0) begin
            next_state.phase = (cur_state.phase >= PH_SOS_NS) ? PH_DATA_FIRST : PH_PREFIX;
         end
      end
   end

endmodule

FILE: rtl/jpeg_marker_segment_parser.sv
// JPEG marker segment parser.
// req_bus carries the file one byte per item, starting just after the
// start-of-image marker. rsp_bus carries at most one record per byte:
// quant entries, Huffman counts and symbols, frame dimensions, frame and
// scan components, entropy-coded data bytes, end of image or format error.
// Both channels use valid/ready; an item moves when both are high.
// Throughput is one byte per cycle while rsp_bus takes records. A record
// appears on rsp_bus the cycle after the byte that causes it is accepted;
// entropy-coded bytes come out one item late, since each is held until the
// next byte shows it is not the start of the end marker.
// The result register decouples the two sides: req_bus.ready stays high
// while the register is empty or being taken, so a stalled receiver stalls
// the input only once a record is waiting.
// After an end or error record every further byte is taken and dropped.
// reset (synchronous, active high) returns the parser to waiting for a
// marker prefix and empties the result register; no clearing pass.
module jpeg_marker_segment_parser
   import jmsp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   jmsp_req_if.sink  req_bus,
   jmsp_rsp_if.source rsp_bus
);

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_ff;
   rsp_type   out_in;
   rsp_type   step_res;
   logic      step_valid;
   logic      accept;

   jmsp_step u_step (
      .cur_state  (state_ff),
      .byte_in    (req_bus.byte_in),
      .next_state (state_in),
      .res_valid  (step_valid),
      .res        (step_res)
   );

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_in       = out_ff;
      if (accept && step_valid) begin
         out_valid_in = 1'b1;
         out_in       = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_ff.kind;
   assign rsp_bus.table_class  = out_ff.table_class;
   assign rsp_bus.table_id     = out_ff.table_id;
   assign rsp_bus.precision    = out_ff.precision;
   assign rsp_bus.entry_index  = out_ff.entry_index;
   assign rsp_bus.value        = out_ff.value;
   assign rsp_bus.component_id = out_ff.component_id;
   assign rsp_bus.h_factor     = out_ff.h_factor;
   assign rsp_bus.v_factor     = out_ff.v_factor;
   assign rsp_bus.table_select = out_ff.table_select;
   assign rsp_bus.ac_select    = out_ff.ac_select;

   // parsing stops for good after end or error
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_STOP |=> state_ff.phase == PH_STOP)
      else $error("parser left the stopped phase");

   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      accept && step_valid && (step_res.kind == KIND_END || step_res.kind == KIND_ERROR)
      |=> state_ff.phase == PH_STOP)
      else $error("end or error record without stopping");

   a_record_lands: assert property (@(posedge clock) disable iff (reset)
      accept && step_valid |=> out_valid_ff && out_ff.kind == $past(step_res.kind))
      else $error("accepted record not in result register");

   a_quant_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DQT_E8 || state_ff.phase == PH_DQT_HI
       || state_ff.phase == PH_DQT_LO) |-> state_ff.field_counter < QUANT_ENTRIES)
      else $error("quant entry index out of range");

   a_data_stays: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_DATA_HELD
      |=> state_ff.phase == PH_DATA_HELD || state_ff.phase == PH_STOP)
      else $error("entropy data phase left without end marker");

endmodule

FILE: tb/tb_jpeg_marker_segment_parser.sv
module tb_jpeg_marker_segment_parser;
   import jmsp_pkg::*;

   localparam logic [7:0] MK_APP0  = 8'hE0;
   localparam logic [7:0] MK_COM   = 8'hFE;
   localparam int         HOLD_AT  = 300;
   localparam int         HOLD_LEN = 80;
   localparam int         SEG_BUDGET = 1300;

   // fill, standalone marker, zero and one lengths, 16-bit quant entry, frame extremes
   localparam logic [27*8-1:0] OPENING = {
      BYTE_PREFIX, BYTE_PREFIX, MK_TEM,
      BYTE_PREFIX, MK_APP0, 8'h00, 8'h00,
      BYTE_PREFIX, MK_COM, 8'h00, 8'h01,
      BYTE_PREFIX, MK_DQT, 8'h00, 8'h05, 8'h1A, 8'hFF, 8'hFF,
      BYTE_PREFIX, MK_SOF0, 8'h00, 8'h07, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00
   };

   logic clock = 1'b0;
   logic reset;

   jmsp_req_if req_bus ();
   jmsp_rsp_if rsp_bus ();

   jpeg_marker_segment_parser u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [7:0] file_bytes [$];
   logic [7:0] seg_body [$];
   rsp_type    pending_records [$];

   int   cycle_no;
   int   hold_left;
   logic quiet;
   int   bytes_taken;
   int   records_taken;
   int   mismatches = 0;
   int   kind_seen [16];
   rsp_type got_rec;
   rsp_type want_rec;

   // parser state as the predictor sees it
   logic [PHASE_W-1:0] seg_phase;
   logic [15:0]        seg_left;
   logic [7:0]         field_cnt;
   logic [11:0]        syms_left;
   logic [4:0]         table_info;
   logic [7:0]         hi_hold;
   logic [7:0]         comps_left;
   logic [7:0]         data_hold;

   assign quiet = (cycle_no >= 500 && cycle_no < 900);

   function automatic string rec_text(rsp_type r);
      return {$sformatf("kind %0d class %0d id %0d prec %0d idx %0d value %04h",
                        r.kind, r.table_class, r.table_id, r.precision, r.entry_index,
                        r.value),
              $sformatf(" comp %02h h %0d v %0d sel %0d ac %0d",
                        r.component_id, r.h_factor, r.v_factor, r.table_select,
                        r.ac_select)};
   endfunction

   task automatic note_mismatch(input string want_txt, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("record %0d: expected %0s, got %0s", records_taken, want_txt, rec_text(got));
   endtask

   task automatic parse_byte(input logic [7:0] b);
      rsp_type            rec;
      logic               emit;
      logic               body;
      logic [PHASE_W-1:0] nxt;
      logic [15:0]        len;
      rec  = '0;
      emit = 1'b0;
      nxt  = seg_phase;
      body = (seg_phase >= PH_SKIP && seg_phase <= PH_SOS_SKIP);
      case (seg_phase)
         PH_PREFIX: begin
            if (b == BYTE_PREFIX) begin
               nxt = PH_MARKER;
            end else begin
               emit = 1'b1;
               rec.kind = KIND_ERROR;
               nxt = PH_STOP;
            end
         end
         PH_MARKER: begin
            if (b == BYTE_PREFIX) begin
               nxt = PH_MARKER;
            end else if (b == MK_EOI) begin
               emit = 1'b1;
               rec.kind = KIND_END;
               nxt = PH_STOP;
            end else if (b == MK_TEM || (b >= MK_RST_LO && b <= MK_SOI)) begin
               nxt = PH_PREFIX;
            end else begin
               case (b)
                  MK_DQT:  table_info = SEG_DQT;
                  MK_DHT:  table_info = SEG_DHT;
                  MK_SOF0: table_info = SEG_SOF;
                  MK_SOS:  table_info = SEG_SOS;
                  default: table_info = SEG_SKIP;
               endcase
               nxt = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            hi_hold = b;
            nxt = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len = {hi_hold, b};
            seg_left = (len >= 16'd2) ? len - 16'd2 : 16'd0;
            case (table_info)
               SEG_DQT: nxt = PH_DQT_HEAD;
               SEG_DHT: nxt = PH_DHT_HEAD;
               SEG_SOF: nxt = PH_SOF_P;
               SEG_SOS: nxt = PH_SOS_NS;
               default: nxt = PH_SKIP;
            endcase
            if (seg_left == 16'd0)
               nxt = (table_info == SEG_SOS) ? PH_DATA_FIRST : PH_PREFIX;
         end
         PH_DATA_FIRST: begin
            data_hold = b;
            nxt = PH_DATA_HELD;
         end
         PH_DATA_HELD: begin
            emit = 1'b1;
            if (data_hold == BYTE_PREFIX && b == MK_EOI) begin
               rec.kind = KIND_END;
               nxt = PH_STOP;
            end else begin
               rec.kind = KIND_DATA;
               rec.value = {8'h00, data_hold};
               data_hold = b;
            end
         end
         PH_SKIP, PH_SOS_SKIP: ;
         PH_DQT_HEAD: begin
            table_info = {(b[7:4] != 4'h0), b[3:0]};
            field_cnt = 8'd0;
            nxt = table_info[4] ? PH_DQT_HI : PH_DQT_E8;
         end
         PH_DQT_E8, PH_DQT_LO: begin
            emit = 1'b1;
            rec.kind = KIND_QUANT;
            rec.table_id = table_info[3:0];
            rec.precision = table_info[4];
            rec.entry_index = field_cnt;
            rec.value = (seg_phase == PH_DQT_LO) ? {hi_hold, b} : {8'h00, b};
            field_cnt = field_cnt + 8'd1;
            if (field_cnt >= QUANT_ENTRIES) nxt = PH_DQT_HEAD;
            else nxt = (seg_phase == PH_DQT_LO) ? PH_DQT_HI : PH_DQT_E8;
         end
         PH_DQT_HI: begin
            hi_hold = b;
            nxt = PH_DQT_LO;
         end
         PH_DHT_HEAD: begin
            table_info = {b[4], b[3:0]};
            field_cnt = 8'd0;
            syms_left = 12'd0;
            nxt = PH_DHT_CNT;
         end
         PH_DHT_CNT, PH_DHT_SYM: begin
            emit = 1'b1;
            rec.kind = (seg_phase == PH_DHT_CNT) ? KIND_HCOUNT : KIND_HSYM;
            rec.table_class = table_info[4];
            rec.table_id = table_info[3:0];
            rec.entry_index = field_cnt;
            rec.value = {8'h00, b};
            field_cnt = field_cnt + 8'd1;
            if (seg_phase == PH_DHT_CNT) begin
               syms_left = syms_left + {4'h0, b};
               if (field_cnt >= HUFF_LENGTHS) begin
                  field_cnt = 8'd0;
                  nxt = (syms_left != 12'd0) ? PH_DHT_SYM : PH_DHT_HEAD;
               end
            end else begin
               syms_left = syms_left - 12'd1;
               nxt = (syms_left != 12'd0) ? PH_DHT_SYM : PH_DHT_HEAD;
            end
         end
         PH_SOF_P: begin
            emit = 1'b1;
            rec.kind = KIND_DIM;
            rec.entry_index = DIM_PRECISION;
            rec.value = {8'h00, b};
            nxt = PH_SOF_YH;
         end
         PH_SOF_YH, PH_SOF_XH: begin
            hi_hold = b;
            nxt = seg_phase + 5'd1;
         end
         PH_SOF_YL, PH_SOF_XL: begin
            emit = 1'b1;
            rec.kind = KIND_DIM;
            rec.entry_index = (seg_phase == PH_SOF_YL) ? DIM_HEIGHT : DIM_WIDTH;
            rec.value = {hi_hold, b};
            nxt = seg_phase + 5'd1;
         end
         PH_SOF_NF: begin
            comps_left = b;
            nxt = (b != 8'd0) ? PH_SOF_CID : PH_SKIP;
         end
         PH_SOF_CID: begin
            hi_hold = b;
            nxt = PH_SOF_HV;
         end
         PH_SOF_HV: begin
            field_cnt = b;
            nxt = PH_SOF_TQ;
         end
         PH_SOF_TQ: begin
            emit = 1'b1;
            rec.kind = KIND_FCOMP;
            rec.component_id = hi_hold;
            rec.h_factor = field_cnt[7:4];
            rec.v_factor = field_cnt[3:0];
            rec.table_select = b[3:0];
            comps_left = comps_left - 8'd1;
            nxt = (comps_left != 8'd0) ? PH_SOF_CID : PH_SKIP;
         end
         PH_SOS_NS: begin
            comps_left = b;
            nxt = (b != 8'd0) ? PH_SOS_CID : PH_SOS_SKIP;
         end
         PH_SOS_CID: begin
            hi_hold = b;
            nxt = PH_SOS_TT;
         end
         PH_SOS_TT: begin
            emit = 1'b1;
            rec.kind = KIND_SCOMP;
            rec.component_id = hi_hold;
            rec.table_select = b[7:4];
            rec.ac_select = b[3:0];
            comps_left = comps_left - 8'd1;
            nxt = (comps_left != 8'd0) ? PH_SOS_CID : PH_SOS_SKIP;
         end
         default: nxt = PH_STOP;
      endcase
      // the segment length wins over whatever structure is still open
      if (body) begin
         seg_left = seg_left - 16'd1;
         if (seg_left == 16'd0)
            nxt = (seg_phase >= PH_SOS_NS) ? PH_DATA_FIRST : PH_PREFIX;
      end
      seg_phase = nxt;
      if (emit) pending_records.push_back(rec);
   endtask

   task automatic add_rand(input int n);
      repeat (n) seg_body.push_back(8'($urandom_range(0, 255)));
   endtask

   // marker plus length and body, sometimes cut short or padded, sometimes after fill or a standalone marker
   task automatic emit_segment(input logic [7:0] marker);
      int r;
      int cut;
      int len;
      if ($urandom_range(0, 9) == 0) begin
         file_bytes.push_back(BYTE_PREFIX);
         file_bytes.push_back(($urandom_range(0, 9) == 0) ? MK_TEM
                              : MK_RST_LO + 8'($urandom_range(0, 8)));
      end
      file_bytes.push_back(BYTE_PREFIX);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) file_bytes.push_back(BYTE_PREFIX);
      file_bytes.push_back(marker);
      r = $urandom_range(0, 99);
      if (r < 10 && seg_body.size() > 0) begin
         cut = $urandom_range(0, seg_body.size() - 1);
         while (seg_body.size() > cut) void'(seg_body.pop_back());
      end else if (r < 20) begin
         add_rand($urandom_range(1, 6));
      end
      len = seg_body.size() + 2;
      file_bytes.push_back(8'(len >> 8));
      file_bytes.push_back(8'(len));
      foreach (seg_body[i]) file_bytes.push_back(seg_body[i]);
   endtask

   task automatic build_dqt();
      logic [7:0] head;
      seg_body.delete();
      repeat ($urandom_range(1, 2)) begin
         head[7:4] = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(1, 15)) : 4'h0;
         head[3:0] = 4'($urandom_range(0, 15));
         seg_body.push_back(head);
         add_rand((head[7:4] != 4'h0) ? 128 : 64);
      end
   endtask

   task automatic build_dht();
      int  total;
      int  c;
      int  r;
      logic none;
      seg_body.delete();
      repeat ($urandom_range(1, 2)) begin
         add_rand(1);
         none = ($urandom_range(0, 9) == 0);
         total = 0;
         for (int k = 0; k < 16; k++) begin
            r = $urandom_range(0, 99);
            if (none) c = 0;
            else if (r < 3) c = $urandom_range(100, 255);
            else c = $urandom_range(0, 2);
            seg_body.push_back(8'(c));
            total += c;
         end
         add_rand(total);
      end
   endtask

   // frame or scan header; the listed components may disagree with the count
   task automatic build_header(input logic is_scan);
      int nc;
      int listed;
      seg_body.delete();
      nc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      listed = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4) : nc;
      if (!is_scan) add_rand(5);
      seg_body.push_back(8'(nc));
      add_rand(listed * (is_scan ? 2 : 3));
      if (is_scan) add_rand(3);
   endtask

   task automatic add_scan_data(input int n);
      int r;
      logic [7:0] b;
      repeat (n) begin
         r = $urandom_range(0, 99);
         b = 8'($urandom_range(0, 255));
         if (r < 8) begin
            file_bytes.push_back(BYTE_PREFIX);
            file_bytes.push_back(8'h00);
         end else if (r < 12) begin
            file_bytes.push_back(BYTE_PREFIX);
            file_bytes.push_back(MK_RST_LO + 8'($urandom_range(0, 7)));
         end else if (b == BYTE_PREFIX || r < 15) begin
            // any follower that cannot close the image
            file_bytes.push_back(BYTE_PREFIX);
            do b = 8'($urandom_range(0, 255));
            while (b == MK_EOI || b == BYTE_PREFIX);
            file_bytes.push_back(b);
         end else begin
            file_bytes.push_back(b);
         end
      end
   endtask

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.byte_in <= 8'h00;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (file_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
            req_bus.valid   <= 1'b1;
            req_bus.byte_in <= file_bytes.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // record receiver with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         cycle_no      <= 0;
      end else begin
         cycle_no <= cycle_no + 1;
         if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (cycle_no == HOLD_AT) begin
            hold_left     <= HOLD_LEN;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // checks records first, then predicts from the byte taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         seg_phase     = PH_PREFIX;
         seg_left      = '0;
         field_cnt     = '0;
         syms_left     = '0;
         table_info    = '0;
         hi_hold       = '0;
         comps_left    = '0;
         data_hold     = '0;
         bytes_taken   = 0;
         records_taken = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_rec.kind         = rsp_bus.kind;
            got_rec.table_class  = rsp_bus.table_class;
            got_rec.table_id     = rsp_bus.table_id;
            got_rec.precision    = rsp_bus.precision;
            got_rec.entry_index  = rsp_bus.entry_index;
            got_rec.value        = rsp_bus.value;
            got_rec.component_id = rsp_bus.component_id;
            got_rec.h_factor     = rsp_bus.h_factor;
            got_rec.v_factor     = rsp_bus.v_factor;
            got_rec.table_select = rsp_bus.table_select;
            got_rec.ac_select    = rsp_bus.ac_select;
            records_taken++;
            kind_seen[got_rec.kind]++;
            if (pending_records.size() == 0) begin
               note_mismatch("nothing", got_rec);
            end else begin
               want_rec = pending_records.pop_front();
               if (got_rec.kind !== want_rec.kind
                   || got_rec.table_class !== want_rec.table_class
                   || got_rec.table_id !== want_rec.table_id
                   || got_rec.precision !== want_rec.precision
                   || got_rec.entry_index !== want_rec.entry_index
                   || got_rec.value !== want_rec.value
                   || got_rec.component_id !== want_rec.component_id
                   || got_rec.h_factor !== want_rec.h_factor
                   || got_rec.v_factor !== want_rec.v_factor
                   || got_rec.table_select !== want_rec.table_select
                   || got_rec.ac_select !== want_rec.ac_select)
                  note_mismatch(rec_text(want_rec), got_rec);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            bytes_taken++;
            parse_byte(req_bus.byte_in);
         end
      end
   end

   initial begin
      int r;
      int drain;
      int missing;
      reset = 1'b1;

      for (int i = 26; i >= 0; i--) file_bytes.push_back(OPENING[i*8 +: 8]);

      while (file_bytes.size() < SEG_BUDGET) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            seg_body.delete();
            add_rand(($urandom_range(0, 19) == 0) ? $urandom_range(250, 300)
                                                  : $urandom_range(0, 30));
            r = $urandom_range(0, 99);
            if (r < 30) begin
               emit_segment(MK_APP0);
            end else if (r < 50) begin
               emit_segment(MK_COM);
            end else begin
               logic [7:0] m;
               do m = 8'($urandom_range(0, 255));
               while (m == BYTE_PREFIX || m == MK_EOI || m == MK_TEM
                      || (m >= MK_RST_LO && m <= MK_SOI) || m == MK_DQT
                      || m == MK_DHT || m == MK_SOF0 || m == MK_SOS);
               emit_segment(m);
            end
         end else if (r < 40) begin
            build_dqt();
            emit_segment(MK_DQT);
         end else if (r < 75) begin
            build_dht();
            emit_segment(MK_DHT);
         end else begin
            build_header(1'b0);
            emit_segment(MK_SOF0);
         end
      end

      // the stream closes once: scan then end, bare end marker, or a bad prefix
      r = $urandom_range(0, 9);
      if (r < 6) begin
         if ($urandom_range(0, 7) == 0) begin
            file_bytes.push_back(BYTE_PREFIX);
            file_bytes.push_back(MK_SOS);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'($urandom_range(0, 1)));
         end else begin
            build_header(1'b1);
            emit_segment(MK_SOS);
         end
         add_scan_data($urandom_range(150, 300));
         file_bytes.push_back(BYTE_PREFIX);
         file_bytes.push_back(MK_EOI);
      end else if (r < 8) begin
         file_bytes.push_back(BYTE_PREFIX);
         file_bytes.push_back(MK_EOI);
      end else begin
         file_bytes.push_back(8'($urandom_range(0, 254)));
      end
      repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (file_bytes.size() == 0);
      @(posedge clock);
      while (req_bus.valid) @(posedge clock);
      drain = 0;
      while (pending_records.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      missing = pending_records.size();
      if (missing != 0 && mismatches < 10)
         $display("%0d expected records never arrived", missing);

      $display("%0d bytes, %0d records: %0d quant, %0d huffman, %0d frame/scan, %0d data",
               bytes_taken, records_taken, kind_seen[KIND_QUANT],
               kind_seen[KIND_HCOUNT] + kind_seen[KIND_HSYM],
               kind_seen[KIND_DIM] + kind_seen[KIND_FCOMP] + kind_seen[KIND_SCOMP],
               kind_seen[KIND_DATA]);
      $display("stream closed by %0s", (kind_seen[KIND_END] != 0) ? "end of image"
               : (kind_seen[KIND_ERROR] != 0) ? "format error" : "nothing");
      if (mismatches == 0 && missing == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/jmsp_pkg.sv
rtl/jmsp_if.sv
rtl/jmsp_step.sv
rtl/jpeg_marker_segment_parser.sv
tb/tb_jpeg_marker_segment_parser.sv
